/* hw/rtl/pfspf_pkg.sv */
`timescale 1ns / 1ps
// Shared widths and defaults of the smallest-prime-factor factorizer.
package pfspf_pkg;

  localparam int VALUE_W       = 16;
  localparam int SCALE_W       = 12;
  localparam int EXP_W         = 16;
  localparam int SPF_W         = 16;
  localparam int MULT_W        = 4;
  localparam int MAX_VALUE_DEF = 65536;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);

endpackage

/* hw/rtl/pfspf_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module pfspf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/prime_factorizer_spf_top.sv */
`timescale 1ns / 1ps
// Top level of the smallest-prime-factor factorizer: sieve, table and divide loop.
//
// After reset the block fills a table of smallest prime factors for 0..MAX_VALUE-1 and
// accepts no value meanwhile: a first sweep writes every entry, then an odd-stride
// sieve reads and marks entries. Configuration writes are taken at any time. Each value
// then takes, per prime occurrence, a registered table read and a 16-step shift-subtract
// divider that takes one quotient bit a cycle; each distinct prime but the last is then
// re-read and handed off, and the last is handed off, each hand-off waiting for a free
// output register. A value below 2 or beyond the table is taken and yields nothing.
// Results wait in an output register, so the block accepts the next value while the last
// result of the previous one is still pending.
module prime_factorizer_spf_top #(
  parameter int MAX_VALUE = pfspf_pkg::MAX_VALUE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfspf_pkg::SCALE_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfspf_pkg::VALUE_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfspf_pkg::VALUE_W-1:0] prime_factor_o,
  output logic [pfspf_pkg::EXP_W-1:0]   exponent_o,
  output logic                          last_o
);

  import pfspf_pkg::*;

  localparam int AW     = $clog2(MAX_VALUE);
  localparam int CMP_W  = (AW + 1 > VALUE_W) ? AW + 1 : VALUE_W;
  localparam int DIV_CW = $clog2(VALUE_W);
  localparam int PROD_W = MULT_W + SCALE_W;

  localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_VALUE - 1);
  localparam logic [AW:0]       I_MAX    = (AW + 1)'(MAX_VALUE);
  localparam logic [AW+1:0]     M_MAX    = (AW + 2)'(MAX_VALUE);
  localparam logic [AW+2:0]     SQ_MAX   = (AW + 3)'(MAX_VALUE);
  localparam logic [CMP_W-1:0]  V_MAX    = CMP_W'(MAX_VALUE);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(VALUE_W - 1);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_ODD_RD  = 4'd1;
  localparam logic [3:0] ST_ODD_CHK = 4'd2;
  localparam logic [3:0] ST_MUL_RD  = 4'd3;
  localparam logic [3:0] ST_MUL_CHK = 4'd4;
  localparam logic [3:0] ST_IDLE    = 4'd5;
  localparam logic [3:0] ST_F_RD    = 4'd6;
  localparam logic [3:0] ST_F_CHK   = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [AW:0]        i_q, i_d;
  logic [AW+2:0]      sq_q, sq_d;
  logic [AW+1:0]      m_q, m_d;
  logic [VALUE_W-1:0] n_q, n_d;
  logic [VALUE_W-1:0] p_q, p_d;
  logic [MULT_W-1:0]  mult_q, mult_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [DIV_CW-1:0]  cnt_q, cnt_d;
  logic               emit_last_q, emit_last_d;
  logic [SCALE_W-1:0] scale_q;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_prime_q, out_prime_d;
  logic [EXP_W-1:0]   out_exp_q, out_exp_d;
  logic               out_last_q, out_last_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SPF_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [SPF_W-1:0]   ram_rdata;

  logic [AW:0]        i_adv;
  logic               i_end;
  logic [AW+2:0]      sq_adv;
  logic               sq_lt;
  logic [AW+1:0]      m_adv;
  logic               m_end;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W:0]   diff;
  logic               ge;
  logic [VALUE_W-1:0] rem_n;
  logic [VALUE_W-1:0] quo_n;
  logic [PROD_W-1:0]  prod;
  logic               in_range;
  logic               slot_free;

  pfspf_ram #(
    .WIDTH(SPF_W),
    .DEPTH(MAX_VALUE)
  ) u_spf_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign i_adv  = i_q + (AW + 1)'(2);
  assign i_end  = i_adv >= I_MAX;
  assign sq_adv = sq_q + {i_q, 2'b00} + (AW + 3)'(4);
  assign sq_lt  = sq_q < SQ_MAX;
  assign m_adv  = m_q + {i_q, 1'b0};
  assign m_end  = m_adv >= M_MAX;

  assign trial = {rem_q, quo_q[VALUE_W-1]};
  assign diff  = trial - {1'b0, p_q};
  assign ge    = trial >= {1'b0, p_q};
  assign rem_n = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
  assign quo_n = {quo_q[VALUE_W-2:0], ge};

  assign prod      = PROD_W'(mult_q) * PROD_W'(scale_q);
  assign in_range  = (value_i >= VALUE_W'(2)) && (CMP_W'(value_i) < V_MAX);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    sq_d        = sq_q;
    m_d         = m_q;
    n_d         = n_q;
    p_d         = p_q;
    mult_d      = mult_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    emit_last_d = emit_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_prime_d = out_prime_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(i_q);
    ram_wdata   = SPF_W'(i_q);
    ram_raddr   = AW'(i_q);

    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (!clr_q[0] && (clr_q != '0)) ? SPF_W'(2) : '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_ODD_RD;
        end
      end
      ST_ODD_RD: begin
        state_d = ST_ODD_CHK;
      end
      ST_ODD_CHK: begin
        if ((ram_rdata == '0) && sq_lt) begin
          ram_we  = 1'b1;
          m_d     = sq_q[AW+1:0];
          state_d = ST_MUL_RD;
        end else begin
          ram_we = (ram_rdata == '0);
          i_d    = i_adv;
          if (sq_lt) begin
            sq_d = sq_adv;
          end
          state_d = i_end ? ST_IDLE : ST_ODD_RD;
        end
      end
      ST_MUL_RD: begin
        ram_raddr = AW'(m_q);
        state_d   = ST_MUL_CHK;
      end
      ST_MUL_CHK: begin
        ram_we    = (ram_rdata == '0);
        ram_waddr = AW'(m_q);
        if (m_end) begin
          i_d = i_adv;
          if (sq_lt) begin
            sq_d = sq_adv;
          end
          state_d = i_end ? ST_IDLE : ST_ODD_RD;
        end else begin
          m_d     = m_adv;
          state_d = ST_MUL_RD;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_range) begin
          n_d     = value_i;
          mult_d  = '0;
          state_d = ST_F_RD;
        end
      end
      ST_F_RD: begin
        ram_raddr = AW'(n_q);
        state_d   = ST_F_CHK;
      end
      ST_F_CHK: begin
        if ((mult_q == '0) || (VALUE_W'(ram_rdata) == p_q)) begin
          p_d     = VALUE_W'(ram_rdata);
          rem_d   = '0;
          quo_d   = n_q;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          emit_last_d = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_DIV: begin
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_LAST) begin
          n_d    = quo_n;
          mult_d = mult_q + MULT_W'(1);
          if (quo_n == VALUE_W'(1)) begin
            emit_last_d = 1'b1;
            state_d     = ST_EMIT;
          end else begin
            state_d = ST_F_RD;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_prime_d = p_q;
          out_exp_d   = EXP_W'(prod);
          out_last_d  = emit_last_q;
          mult_d      = '0;
          state_d     = emit_last_q ? ST_IDLE : ST_F_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      i_q         <= (AW + 1)'(3);
      sq_q        <= (AW + 3)'(9);
      mult_q      <= '0;
      cnt_q       <= '0;
      emit_last_q <= 1'b0;
      scale_q     <= SCALE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      sq_q        <= sq_d;
      mult_q      <= mult_d;
      cnt_q       <= cnt_d;
      emit_last_q <= emit_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q         <= m_d;
    n_q         <= n_d;
    p_q         <= p_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_prime_q <= out_prime_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign prime_factor_o = out_prime_q;
  assign exponent_o     = out_exp_q;
  assign last_o         = out_last_q;

endmodule

/* hw/rtl/pfspf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the factorizer and its bind to the top level.
module pfspf_checker #(
  parameter int MAX_VALUE = pfspf_pkg::MAX_VALUE_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [pfspf_pkg::VALUE_W-1:0] value_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [pfspf_pkg::VALUE_W-1:0] prime_factor_o,
  input logic [pfspf_pkg::EXP_W-1:0]   exponent_o,
  input logic                          last_o
);

  import pfspf_pkg::*;

  localparam int AW    = $clog2(MAX_VALUE);
  localparam int CMP_W = (AW + 1 > VALUE_W) ? AW + 1 : VALUE_W;

  logic               pending_q;
  logic [VALUE_W-1:0] prev_prime_q;
  logic               in_range;

  assign in_range = (value_i >= VALUE_W'(2)) && (CMP_W'(value_i) < CMP_W'(MAX_VALUE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      pending_q <= !last_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      prev_prime_q <= prime_factor_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prime_factor_o)
      && $stable(exponent_o) && $stable(last_o))
  else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
  else $error("new value taken before its predecessor finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_range |=> !in_ready_o)
  else $error("factorizable value produced no work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pending_q |-> prime_factor_o > prev_prime_q)
  else $error("primes of one value not strictly ascending");

endmodule

bind prime_factorizer_spf_top pfspf_checker #(.MAX_VALUE(MAX_VALUE)) u_pfspf_checker (.*);
